FILE: rtl/ohr_pkg.sv
// Package: sizes, command and status codes, and the pipeline record of the history ring.
`default_nettype none
package ohr_pkg;

    localparam int DEPTH      = 1024;
    localparam int ELEM_WIDTH = 32;

    // Fixed field widths of the transaction payloads
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int FSLOT_W = 10;
    localparam int CFG_W   = 11;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int MEM_W  = (ELEM_WIDTH < WORD_W) ? ELEM_WIDTH : WORD_W;

    localparam logic [CMD_W-1:0] CMD_INSERT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK_NEWEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK   = 2'd2;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NO_DATA = 1'b1;

    typedef struct packed {
        logic               status;
        logic               use_mem;
        logic [WORD_W-1:0]  batch;
        logic [FSLOT_W-1:0] slot;
    } t_stage;

endpackage
`default_nettype wire

FILE: rtl/ohr_if.sv
// Interfaces: request and result channels of the history ring.
`default_nettype none
interface ohr_in_if
    import ohr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [WORD_W-1:0]  write_data;
    logic [WORD_W-1:0]  reader_batch;
    logic [FSLOT_W-1:0] reader_slot;
    logic [FSLOT_W-1:0] back_offset;

    modport source (
        output valid, command, write_data, reader_batch, reader_slot, back_offset,
        input  ready
    );
    modport sink (
        input  valid, command, write_data, reader_batch, reader_slot, back_offset,
        output ready
    );
endinterface

interface ohr_out_if
    import ohr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               status;
    logic [WORD_W-1:0]  read_data;
    logic [WORD_W-1:0]  seen_batch;
    logic [FSLOT_W-1:0] seen_slot;

    modport source (
        output valid, status, read_data, seen_batch, seen_slot,
        input  ready
    );
    modport sink (
        input  valid, status, read_data, seen_batch, seen_slot,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/overwrite_history_ring_top.sv
// Top level: overwrite history ring with insert, peek-newest and peek-back commands.
`default_nettype none
// Circular history buffer that always overwrites. Every accepted request transaction
// gives exactly one result transaction, in order. Throughput is one transaction per
// clock while the output is not stalled. A result passes from the stage register to
// the output register, and either can be held by back-pressure. The ring memory has
// a single port with a registered read, which the stage register waits for. Request
// handling and all state updates (newest slot, wrap count) happen at the accepting
// edge. The memory read data and the result record are captured at that edge, side
// by side in the stage, and move to the output register together.
// Inserts go to the slot after the newest one, wrapping to slot 0 and counting a wrap;
// the first insert after reset lands in slot 0 with wrap count 1. Peek-newest answers
// no-data unless the stored newest position is strictly newer than the reader position
// (wrap count first, then slot). Peek-back answers no-data when the distance reaches
// unwritten slots or is at least the ring length. The ring length register (0 acts as
// 1, above the depth acts as the depth) must be written only while the block is idle.
// The memory is not cleared after reset; a no-data result gives zero read data.
module overwrite_history_ring_top
    import ohr_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    ohr_in_if.sink           i_in,
    ohr_out_if.source        o_out,
    input  wire              i_cfg_we,
    input  wire [CFG_W-1:0]  i_cfg_wdata
);

    // Ring state
    logic [SLOT_W-1:0] r_newest;
    logic              r_has_data;
    logic [WORD_W-1:0] r_wrap;
    logic [LEN_W-1:0]  r_len;

    // Ring memory and its registered read port
    logic [MEM_W-1:0]  r_mem [DEPTH];
    logic [MEM_W-1:0]  r_mem_q;

    // Stage register (waits for the memory read) and output register
    logic              r_s1_valid;
    t_stage            r_s1;
    logic              r_out_valid;
    logic              r_out_status;
    logic [WORD_W-1:0] r_out_data;
    logic [WORD_W-1:0] r_out_batch;
    logic [FSLOT_W-1:0] r_out_slot;

    logic              w_accept;
    logic              w_s1_move;
    logic              w_out_load;

    logic [LEN_W-1:0]  w_next_wide;
    logic [SLOT_W-1:0] w_ins_slot;
    logic              w_newer;
    logic [LEN_W-1:0]  w_newest_wide;
    logic [LEN_W-1:0]  w_offset_wide;
    logic [LEN_W-1:0]  w_avail;
    logic [LEN_W-1:0]  w_back_wide;
    logic              w_back_ok;
    logic [SLOT_W-1:0] w_rd_addr;
    logic [LEN_W-1:0]  w_cfg_len;

    logic [SLOT_W-1:0] n_newest;
    logic              n_has_data;
    logic [WORD_W-1:0] n_wrap;
    t_stage            n_s1;

    // Handshake: stage register frees when it moves on; output register when taken
    assign w_s1_move  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_load = w_s1_move;

    // Clamp the ring length on write
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_len = LEN_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(DEPTH)) begin
            w_cfg_len = LEN_W'(DEPTH);
        end else begin
            w_cfg_len = LEN_W'(i_cfg_wdata);
        end
    end

    // Insert target: slot after the newest, wrap to 0 at the ring length
    always_comb begin
        w_next_wide = LEN_W'(r_newest) + LEN_W'(1);
        if (!r_has_data || w_next_wide >= r_len) begin
            w_ins_slot = '0;
        end else begin
            w_ins_slot = SLOT_W'(w_next_wide);
        end
    end

    // Peek-newest: stored newest position strictly newer than the reader's
    assign w_newer = r_has_data &&
        ((i_in.reader_batch < r_wrap) ||
         ((i_in.reader_batch == r_wrap) && (32'(i_in.reader_slot) < 32'(r_newest))));

    // Peek-back: availability and wrapped slot
    always_comb begin
        w_newest_wide = LEN_W'(r_newest);
        w_offset_wide = LEN_W'(i_in.back_offset);
        w_avail       = (r_wrap == 32'd1) ? (w_newest_wide + LEN_W'(1)) : r_len;
        w_back_ok     = r_has_data && (w_offset_wide < r_len) && (w_offset_wide < w_avail);
        if (w_newest_wide >= w_offset_wide) begin
            w_back_wide = w_newest_wide - w_offset_wide;
        end else begin
            w_back_wide = r_len + w_newest_wide - w_offset_wide;
        end
    end

    // Next state, read address and result record for the accepted transaction
    always_comb begin
        n_newest     = r_newest;
        n_has_data   = r_has_data;
        n_wrap       = r_wrap;
        w_rd_addr    = r_newest;
        n_s1.status  = ST_NO_DATA;
        n_s1.use_mem = 1'b0;
        n_s1.batch   = '0;
        n_s1.slot    = '0;
        unique case (i_in.command)
            CMD_INSERT: begin
                n_newest    = w_ins_slot;
                n_has_data  = 1'b1;
                n_wrap      = (w_ins_slot == '0) ? (r_wrap + 32'd1) : r_wrap;
                n_s1.status = ST_OK;
                n_s1.batch  = n_wrap;
                n_s1.slot   = FSLOT_W'(w_ins_slot);
            end
            CMD_PEEK_NEWEST: begin
                if (w_newer) begin
                    n_s1.status  = ST_OK;
                    n_s1.use_mem = 1'b1;
                    n_s1.batch   = r_wrap;
                    n_s1.slot    = FSLOT_W'(r_newest);
                end else begin
                    // Echo the reader position unchanged
                    n_s1.batch = i_in.reader_batch;
                    n_s1.slot  = i_in.reader_slot;
                end
            end
            CMD_PEEK_BACK: begin
                w_rd_addr = SLOT_W'(w_back_wide);
                if (w_back_ok) begin
                    n_s1.status  = ST_OK;
                    n_s1.use_mem = 1'b1;
                end
            end
            default: begin
                // Unused code: no-data, all fields zero, state unchanged
                n_s1.status = ST_NO_DATA;
            end
        endcase
    end

    // Ring memory: write on insert, registered read on any other accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.command == CMD_INSERT) begin
            r_mem[w_ins_slot] <= i_in.write_data[MEM_W-1:0];
        end
        if (w_accept && i_in.command != CMD_INSERT) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest    <= '0;
            r_has_data  <= 1'b0;
            r_wrap      <= '0;
            r_len       <= LEN_W'(DEPTH);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= w_cfg_len;
            end
            if (w_accept) begin
                r_newest   <= n_newest;
                r_has_data <= n_has_data;
                r_wrap     <= n_wrap;
            end
            // Advance the stage register; hold it while the output is stalled
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_out_load) begin
            r_out_status <= r_s1.status;
            r_out_data   <= r_s1.use_mem ? WORD_W'(r_mem_q) : '0;
            r_out_batch  <= r_s1.batch;
            r_out_slot   <= r_s1.slot;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.read_data  = r_out_data;
    assign o_out.seen_batch = r_out_batch;
    assign o_out.seen_slot  = r_out_slot;

endmodule
`default_nettype wire
